// File: hw/rtl/cht_pkg.sv
// cht_pkg: shared types, constants and codes for the chained hash table.
// Used by cht_front, cht_back and chained_hash_table; no dependencies.
package cht_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int NODES_DEF   = 256;
    localparam int KEY_W       = 31;
    localparam int CNT_W       = 9;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

endpackage

// File: hw/rtl/cht_front.sv
// cht_front: accepts commands, reduces the key to a bucket by restoring
// division (one remainder bit a cycle), then holds the item in a one-entry queue.
// Depends on cht_pkg.
module cht_front #(
    parameter int BW = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic [cht_pkg::KEY_W-1:0]   key,
    input  logic [cht_pkg::KEY_W-1:0]   value,
    input  logic [BW:0]                 modulus,
    output logic                        q_valid,
    input  logic                        q_ready,
    output logic [1:0]                  q_kind,
    output logic [cht_pkg::KEY_W-1:0]   q_key,
    output logic [cht_pkg::KEY_W-1:0]   q_value,
    output logic [BW-1:0]               q_bucket
);
    localparam int KW = cht_pkg::KEY_W;
    localparam int SW = $clog2(KW + 1);

    logic          run_reg, run_next;
    logic [SW-1:0] step_reg, step_next;
    logic [BW:0]   rem_reg, rem_next;
    logic [KW-1:0] kd_reg, kd_next;
    logic [1:0]    kind_reg;
    logic [KW-1:0] key_reg, val_reg;
    logic [BW:0]   mod_reg;
    logic [1:0]    qk_reg;
    logic [KW-1:0] qkey_reg, qval_reg;
    logic [BW-1:0] qb_reg;
    logic          qv_reg, qv_next;
    logic [BW+1:0] trial;

    assign busy = run_reg || qv_reg;
    assign trial = {rem_reg, kd_reg[KW-1]};

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        kd_next   = kd_reg;
        qv_next   = qv_reg && !q_ready;
        if (start && !busy)
        begin
            run_next  = 1'b1;
            step_next = '0;
            rem_next  = '0;
            kd_next   = key;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, mod_reg})
                rem_next = (BW+1)'(trial - {1'b0, mod_reg});
            else
                rem_next = trial[BW:0];
            kd_next   = kd_reg << 1;
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(KW - 1))
            begin
                run_next = 1'b0;
                qv_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            qv_reg  <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            qv_reg  <= qv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        kd_reg   <= kd_next;
        if (start && !busy)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            val_reg  <= value;
            if (modulus == '0)
                mod_reg <= (BW+1)'(1);
            else if (modulus > (BW+1)'(1 << BW))
                mod_reg <= (BW+1)'(1 << BW);
            else
                mod_reg <= modulus;
        end
        if (run_reg && step_reg == SW'(KW - 1))
        begin
            qk_reg   <= kind_reg;
            qkey_reg <= key_reg;
            qval_reg <= val_reg;
            qb_reg   <= rem_next[BW-1:0];
        end
    end

    assign q_valid  = qv_reg;
    assign q_kind   = qk_reg;
    assign q_key    = qkey_reg;
    assign q_value  = qval_reg;
    assign q_bucket = qb_reg;
endmodule

// File: hw/rtl/cht_back.sv
// cht_back: executes insert/delete/find against bucket heads and node memories.
// Depends on cht_pkg.
module cht_back #(
    parameter int BW = 6,
    parameter int NW = 8,
    parameter int BUCKETS = 64,
    parameter int NODES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  logic [1:0]                q_kind,
    input  logic [cht_pkg::KEY_W-1:0] q_key,
    input  logic [cht_pkg::KEY_W-1:0] q_value,
    input  logic [BW-1:0]             q_bucket,
    output logic                      done,
    output logic [1:0]                status,
    output logic [cht_pkg::KEY_W-1:0] found_value,
    output logic [cht_pkg::CNT_W-1:0] entries
);
    localparam int KW = cht_pkg::KEY_W;
    localparam int PW = NW + 1;
    localparam logic [PW-1:0] NUL = PW'(NODES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_MATCH = 3'd5;
    localparam logic [2:0] S_TAIL  = 3'd6;
    localparam logic [2:0] S_FREE  = 3'd7;

    logic [PW-1:0] head_mem [BUCKETS];
    logic [BUCKETS-1:0] hvalid_reg;
    logic [KW-1:0] key_mem [NODES];
    logic [KW-1:0] val_mem [NODES];
    logic [PW-1:0] link_mem [NODES];

    logic [2:0]    st_reg;
    logic [1:0]    kind_reg;
    logic [KW-1:0] key_reg, val_reg;
    logic [BW-1:0] bk_reg;
    logic [PW-1:0] cur_reg, prev_reg, free_reg;
    logic [PW-1:0] fresh_reg;
    logic [cht_pkg::CNT_W-1:0] cnt_reg;
    logic [PW-1:0] head_rd;
    logic [KW-1:0] nkey_rd, nval_rd;
    logic [PW-1:0] nlink_rd;
    logic [1:0]    stat_reg;
    logic [KW-1:0] fv_reg;
    logic          done_reg;

    logic [PW-1:0] head_eff;
    logic [PW-1:0] ins_node;
    logic          hit;
    logic          node_we, head_we, link_we;
    logic [PW-1:0] head_din, link_din;
    logic [NW-1:0] link_addr;

    assign q_ready  = (st_reg == S_IDLE);
    assign head_eff = hvalid_reg[bk_reg] ? head_rd : NUL;
    assign hit      = (nkey_rd == key_reg);

    // node for an insert: recycled first, then the next never-used one
    always_comb
    begin
        ins_node = NUL;
        if (free_reg != NUL)
            ins_node = free_reg;
        else if (fresh_reg != NUL)
            ins_node = fresh_reg;
    end

    // one write port per memory
    always_comb
    begin
        node_we   = 1'b0;
        head_we   = 1'b0;
        head_din  = ins_node;
        link_we   = 1'b0;
        link_addr = ins_node[NW-1:0];
        link_din  = head_eff;
        unique case (st_reg)
            S_READ:
            begin
                if (kind_reg == cht_pkg::KIND_INSERT && ins_node != NUL)
                begin
                    node_we = 1'b1;
                    head_we = 1'b1;
                    link_we = 1'b1;
                end
            end
            S_MATCH:
            begin
                if (hit && kind_reg == cht_pkg::KIND_DELETE)
                begin
                    if (prev_reg != NUL)
                    begin
                        link_we   = 1'b1;
                        link_addr = prev_reg[NW-1:0];
                        link_din  = nlink_rd;
                    end
                    else
                    begin
                        head_we  = 1'b1;
                        head_din = nlink_rd;
                    end
                end
            end
            S_FREE:
            begin
                // removed node goes on top of the free list
                link_we   = 1'b1;
                link_addr = cur_reg[NW-1:0];
                link_din  = free_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            key_mem[ins_node[NW-1:0]] <= key_reg;
            val_mem[ins_node[NW-1:0]] <= val_reg;
        end
        if (link_we)
            link_mem[link_addr] <= link_din;
        if (head_we)
            head_mem[bk_reg] <= head_din;
        head_rd  <= head_mem[bk_reg];
        nkey_rd  <= key_mem[cur_reg[NW-1:0]];
        nval_rd  <= val_mem[cur_reg[NW-1:0]];
        nlink_rd <= link_mem[cur_reg[NW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            hvalid_reg <= '0;
            free_reg   <= NUL;
            fresh_reg  <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            kind_reg   <= cht_pkg::KIND_INSERT;
            key_reg    <= '0;
            val_reg    <= '0;
            bk_reg     <= '0;
            cur_reg    <= NUL;
            prev_reg   <= NUL;
            stat_reg   <= cht_pkg::ST_OK;
            fv_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        kind_reg <= q_kind;
                        key_reg  <= q_key;
                        val_reg  <= q_value;
                        bk_reg   <= q_bucket;
                        cur_reg  <= free_reg;
                        st_reg   <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    // head_rd and free node link valid next cycle
                    st_reg <= S_READ;
                end
                S_READ:
                begin
                    fv_reg <= '0;
                    if (kind_reg == cht_pkg::KIND_INSERT)
                    begin
                        if (ins_node != NUL)
                        begin
                            if (free_reg != NUL)
                                free_reg <= nlink_rd;
                            else
                                fresh_reg <= fresh_reg + 1'b1;
                            hvalid_reg[bk_reg] <= 1'b1;
                            cnt_reg  <= cnt_reg + 1'b1;
                            stat_reg <= cht_pkg::ST_OK;
                        end
                        else
                            stat_reg <= cht_pkg::ST_FULL;
                        st_reg <= S_DONE;
                    end
                    else if (kind_reg == cht_pkg::KIND_DELETE ||
                             kind_reg == cht_pkg::KIND_FIND)
                    begin
                        stat_reg <= cht_pkg::ST_NOTFOUND;
                        prev_reg <= NUL;
                        cur_reg  <= head_eff;
                        st_reg   <= (head_eff == NUL) ? S_DONE : S_CMP;
                    end
                    else
                    begin
                        stat_reg <= cht_pkg::ST_OK;
                        st_reg   <= S_DONE;
                    end
                end
                S_CMP:
                begin
                    // cur_reg was set on entry; the node memories are read at cur here, registered for S_MATCH
                    st_reg <= S_MATCH;
                end
                S_MATCH:
                begin
                    if (hit)
                    begin
                        stat_reg <= cht_pkg::ST_OK;
                        if (kind_reg == cht_pkg::KIND_FIND)
                        begin
                            fv_reg <= nval_rd;
                            st_reg <= S_DONE;
                        end
                        else
                            st_reg <= S_FREE;
                    end
                    else if (nlink_rd == NUL)
                        st_reg <= S_DONE;
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= nlink_rd;
                        st_reg   <= S_CMP;
                    end
                end
                S_FREE:
                begin
                    free_reg <= cur_reg;
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - 1'b1;
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= S_TAIL;
                end
                S_TAIL:
                    st_reg <= S_IDLE;
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = stat_reg;
    assign found_value = fv_reg;
    assign entries     = cnt_reg;
endmodule

// File: hw/rtl/chained_hash_table.sv
// chained_hash_table: key-to-value map, separately chained, bucket = key mod count.
// An item passes the front's key reduction (one bit a cycle) and one-entry queue, then
// the back's head read, a compare per chain node walked and, for a delete that hits, a
// free step. The front can reduce the next key while the back still runs the previous item.
// Reset (rst_n low, async) empties all buckets, the free list and the entry count.
// The receiver cannot stall: each result is shown on done for exactly one cycle.
module chained_hash_table #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int NODES   = cht_pkg::NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [30:0] key,
    input  logic [30:0] value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [30:0] found_value,
    output logic [8:0]  entries
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES);

    logic [6:0] bcount_reg;
    logic       q_valid, q_ready;
    logic [1:0] q_kind;
    logic [30:0] q_key, q_value;
    logic [BW-1:0] q_bucket;
    logic front_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcount_reg <= 7'd64;
        else if (cfg_valid)
            bcount_reg <= cfg_data;
    end

    // bucket count saturated into the front's modulus width
    logic [BW:0] modulus;
    assign modulus = (int'(bcount_reg) > BUCKETS) ? (BW+1)'(BUCKETS) : (BW+1)'(bcount_reg);

    cht_front #(.BW(BW)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(front_busy),
        .kind(kind), .key(key), .value(value), .modulus(modulus),
        .q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind),
        .q_key(q_key), .q_value(q_value), .q_bucket(q_bucket)
    );

    assign busy = front_busy;

    cht_back #(.BW(BW), .NW(NW), .BUCKETS(BUCKETS), .NODES(NODES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(q_kind), .q_key(q_key), .q_value(q_value), .q_bucket(q_bucket),
        .done(done), .status(status), .found_value(found_value), .entries(entries)
    );
endmodule

// File: hw/rtl/cht_checker.sv
// cht_checker: port-level assertions for chained_hash_table, bound to the top.
// Depends on the top level's ports only.
module cht_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic [8:0] entries
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than a cycle");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3) else $error("bad status");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        entries <= 9'd256) else $error("entries overflow");
endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .status(status), .entries(entries)
);

// File: tb/chained_hash_table_tb.sv
// chained_hash_table_tb: self-checking testbench for the chained hash table.
// Depends on cht_pkg and the chained_hash_table RTL; standalone otherwise.
`timescale 1ns / 1ps

module chained_hash_table_tb;

    localparam int NB        = 64;
    localparam int NN        = 256;
    localparam int NIL       = NN;
    localparam int LIMIT     = 3000000;
    localparam int SETTLE    = 60;   // idle cycles before a config write
    localparam int DRAIN     = 100;  // cycles after the last result
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct {
        bit         is_cfg;
        logic [6:0] cfg;
        logic [1:0] op;
        logic [30:0] k;
        logic [30:0] v;
    } beat_t;

    typedef struct {
        logic [1:0]  st;
        logic [30:0] fv;
        logic [8:0]  cnt;
    } outcome_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  kind = '0;
    logic [30:0] key = '0;
    logic [30:0] value = '0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        done;
    logic [1:0]  status;
    logic [30:0] found_value;
    logic [8:0]  entries;

    chained_hash_table uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .key(key), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .status(status), .found_value(found_value), .entries(entries)
    );

    // Shadow copy of the table
    logic [6:0]  mod_reg;
    int unsigned heads [NB];
    int unsigned nkey [NN];
    int unsigned nval [NN];
    int unsigned nlink [NN];
    int unsigned free_top;
    int unsigned fresh;
    int unsigned stored;

    beat_t    pending [$];
    outcome_t expected [$];
    int       errors = 0;
    int       sent = 0;
    int       settle = 0;
    int       cycles = 0;

    function automatic outcome_t predict_op(logic [1:0] op, logic [30:0] k, logic [30:0] v);
        outcome_t    r;
        int unsigned m;
        int unsigned b;
        int unsigned n;
        int unsigned cur;
        int unsigned prev;
        r.st = cht_pkg::ST_OK;
        r.fv = '0;
        m = 32'(mod_reg);
        if (m == 0) m = 1;
        if (m > NB) m = NB;
        b = 32'(k) % m;
        if (op == cht_pkg::KIND_INSERT)
        begin
            n = NIL;
            if (free_top < NN)
            begin
                n = free_top;
                free_top = nlink[n];
            end
            else if (fresh < NN)
            begin
                n = fresh;
                fresh++;
            end
            if (n < NN)
            begin
                nkey[n] = 32'(k);
                nval[n] = 32'(v);
                nlink[n] = heads[b];
                heads[b] = n;
                stored++;
            end
            else
                r.st = cht_pkg::ST_FULL;
        end
        else if (op == cht_pkg::KIND_DELETE || op == cht_pkg::KIND_FIND)
        begin
            r.st = cht_pkg::ST_NOTFOUND;
            prev = NIL;
            cur = heads[b];
            for (int s = 0; cur < NN && s < NN; s++)
            begin
                if (nkey[cur] == 32'(k))
                begin
                    r.st = cht_pkg::ST_OK;
                    if (op == cht_pkg::KIND_FIND)
                        r.fv = 31'(nval[cur]);
                    else
                    begin
                        if (prev < NN) nlink[prev] = nlink[cur];
                        else heads[b] = nlink[cur];
                        nlink[cur] = free_top;
                        free_top = cur;
                        if (stored > 0) stored--;
                    end
                    break;
                end
                prev = cur;
                cur = nlink[cur];
            end
        end
        r.cnt = stored[8:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    task automatic push_op(logic [1:0] op, logic [30:0] k, logic [30:0] v);
        beat_t b;
        b.is_cfg = 0; b.cfg = '0; b.op = op; b.k = k; b.v = v;
        pending.push_back(b);
    endtask

    task automatic push_cfg(logic [6:0] c);
        beat_t b;
        b.is_cfg = 1; b.cfg = c; b.op = '0; b.k = '0; b.v = '0;
        pending.push_back(b);
    endtask

    function automatic logic [30:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 31'($urandom_range(0, 40));
        return 31'($urandom);
    endfunction

    // Random ops; ins_pct sets the insert share, a few unused kinds mixed in
    task automatic push_random(int count, int ins_pct);
        int r;
        logic [1:0] op;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) op = cht_pkg::KIND_INSERT;
            else if (r >= 97) op = KIND_NONE;
            else if (r[0]) op = cht_pkg::KIND_DELETE;
            else op = cht_pkg::KIND_FIND;
            push_op(op, pick_key(), 31'($urandom));
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Cycle watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: one op beat or config beat at a time; config only when idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            cfg_valid <= 0;
            settle <= 0;
        end
        else
        begin : drive
            bit accepted;
            bit launched;
            int idle_pct;
            accepted = start && !busy;
            launched = 1'b0;
            if (accepted)
            begin
                expected.push_back(predict_op(kind, key, value));
                sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                mod_reg = cfg_data;
                cfg_valid <= 0;
            end
            if (expected.size() == 0 && !start && !cfg_valid && !accepted)
                settle <= settle + 1;
            else
                settle <= 0;
            idle_pct = (sent < 217) ? 19 : (sent < 434) ? 55 : 0;
            if (!start || accepted)
            begin
                if (pending.size() > 0 && !pending[0].is_cfg && !cfg_valid
                    && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1;
                    kind <= pending[0].op;
                    key <= pending[0].k;
                    value <= pending[0].v;
                    void'(pending.pop_front());
                    launched = 1'b1;
                end
                else
                    start <= 0;
            end
            if (!launched && pending.size() > 0 && pending[0].is_cfg && !cfg_valid
                && !start && settle >= SETTLE)
            begin
                cfg_valid <= 1;
                cfg_data <= pending[0].cfg;
                void'(pending.pop_front());
            end
        end
    end

    // Monitor: each done beat checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected.size() == 0)
                report("unexpected result beat", 32'd1, 32'd0);
            else
            begin : chk
                outcome_t e;
                e = expected.pop_front();
                if (status !== e.st) report("status", 32'(status), 32'(e.st));
                if (found_value !== e.fv)
                    report("found_value", 32'(found_value), 32'(e.fv));
                if (entries !== e.cnt) report("entries", 32'(entries), 32'(e.cnt));
            end
        end
    end

    initial
    begin
        mod_reg = 7'd64;
        for (int i = 0; i < NB; i++) heads[i] = NIL;
        for (int i = 0; i < NN; i++)
        begin
            nkey[i] = 0; nval[i] = 0; nlink[i] = 0;
        end
        free_top = NIL;
        fresh = 0;
        stored = 0;

        // Directed: extremes, duplicates, misses, unused kind
        push_op(cht_pkg::KIND_FIND, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_DELETE, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_INSERT, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_INSERT, 31'h7FFFFFFF, 31'h7FFFFFFF);
        push_op(cht_pkg::KIND_FIND, 31'd0, 31'h7FFFFFFF);
        push_op(cht_pkg::KIND_FIND, 31'h7FFFFFFF, 31'd0);
        push_op(cht_pkg::KIND_INSERT, 31'd0, 31'd5);
        push_op(cht_pkg::KIND_INSERT, 31'd64, 31'd9);
        push_op(cht_pkg::KIND_FIND, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_DELETE, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_FIND, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_DELETE, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_DELETE, 31'd0, 31'd0);
        push_op(cht_pkg::KIND_FIND, 31'd64, 31'd0);
        push_op(KIND_NONE, 31'h7FFFFFFF, 31'h7FFFFFFF);
        push_op(cht_pkg::KIND_DELETE, 31'h7FFFFFFF, 31'd0);
        push_op(cht_pkg::KIND_FIND, 31'd12345, 31'd0);
        // Zero count acts as one bucket; old chains stay put
        push_cfg(7'd0);
        push_op(cht_pkg::KIND_INSERT, 31'd3, 31'd33);
        push_op(cht_pkg::KIND_FIND, 31'd64, 31'd0);
        push_op(cht_pkg::KIND_FIND, 31'd3, 31'd0);
        // Count above the bucket array saturates
        push_cfg(7'd127);
        push_op(cht_pkg::KIND_FIND, 31'd3, 31'd0);
        push_op(cht_pkg::KIND_INSERT, 31'd127, 31'd1);
        push_op(cht_pkg::KIND_FIND, 31'd127, 31'd0);

        push_cfg(7'd64);
        push_random(150, 40);
        // Insert-heavy on few buckets to run the pool dry
        push_cfg(7'd5);
        push_random(300, 88);
        push_cfg(7'd1);
        push_random(60, 45);
        push_cfg(7'($urandom_range(2, 63)));
        push_random(140, 15);

        repeat (7) @(posedge clk);
        rst_n <= 1;

        while (pending.size() != 0 || start || cfg_valid || expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: chained_hash_table.f
hw/rtl/cht_pkg.sv
hw/rtl/cht_front.sv
hw/rtl/cht_back.sv
hw/rtl/chained_hash_table.sv
hw/rtl/cht_checker.sv
tb/chained_hash_table_tb.sv
